/* rtl/cbmb_pkg.sv */
// ----------------------------------------------------------------------------
// cbmb_pkg
// shared constants, tables and types of the colour bar / multiburst generator
// ----------------------------------------------------------------------------
package cbmb_pkg;

	localparam int CBMB_LINE_SAMPLES = 720;
	localparam int CBMB_FRAME_ROWS   = 576;

	localparam int CBMB_ADDR_W = 6;
	localparam int CBMB_DATA_W = 64;
	localparam int CBMB_PAIR_W = 48;

	// register indexes
	localparam logic [2:0] REG_BARS_WY      = 3'd0;
	localparam logic [2:0] REG_BARS_CG      = 3'd1;
	localparam logic [2:0] REG_BARS_MR      = 3'd2;
	localparam logic [2:0] REG_BARS_BK      = 3'd3;
	localparam logic [2:0] REG_BOX_ENABLE   = 3'd4;
	localparam logic [2:0] REG_BOX_BOTTOM   = 3'd5;

	localparam logic [9:0] BOX_BOTTOM_RST   = 10'd218;

	localparam int BOX_X0     = 180;
	localparam int BOX_X1     = 540;
	localparam int BURST_X0   = 112;
	localparam int BURST_LEN  = 96;
	localparam int BURST_STEP = 100;
	localparam int BURST_CNT  = 6;

	localparam logic [7:0] LUMA_BLACK = 8'd16;
	localparam logic [7:0] LUMA_WHITE = 8'd235;
	localparam logic [7:0] LUMA_MID   = 8'd126;
	localparam logic [7:0] CHROMA_MID = 8'd128;

	// burst luma source
	localparam logic [1:0] BL_CONST = 2'd0;
	localparam logic [1:0] BL_P27   = 2'd1;
	localparam logic [1:0] BL_P45   = 2'd2;

	// reciprocals for the phase remainder
	localparam logic [10:0] RECIP27 = 11'd1214;  // 2^15 / 27, rounded up
	localparam logic [10:0] RECIP45 = 11'd1457;  // 2^16 / 45, rounded up

	localparam logic [4:0] BURST_STEPS [BURST_CNT] = '{5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd16};

	localparam logic [7:0] PER27 [27] = '{
		8'd126, 8'd141, 8'd156, 8'd168, 8'd179, 8'd187, 8'd191, 8'd192, 8'd189,
		8'd183, 8'd174, 8'd162, 8'd149, 8'd134, 8'd118, 8'd103, 8'd90,  8'd78,
		8'd69,  8'd63,  8'd60,  8'd61,  8'd65,  8'd73,  8'd84,  8'd96,  8'd111};

	localparam logic [7:0] PER45 [45] = '{
		8'd126, 8'd135, 8'd144, 8'd153, 8'd161, 8'd168, 8'd175, 8'd181, 8'd185,
		8'd189, 8'd191, 8'd192, 8'd192, 8'd190, 8'd187, 8'd183, 8'd178, 8'd172,
		8'd165, 8'd157, 8'd149, 8'd140, 8'd131, 8'd121, 8'd112, 8'd103, 8'd95,
		8'd87,  8'd80,  8'd74,  8'd69,  8'd65,  8'd62,  8'd60,  8'd60,  8'd61,
		8'd63,  8'd67,  8'd71,  8'd77,  8'd84,  8'd91,  8'd99,  8'd108, 8'd117};

	typedef struct packed {
		logic       en;
		logic [9:0] bottom;
	} cbmb_box_t;

endpackage

/* rtl/cbmb_cfg.sv */
// ----------------------------------------------------------------------------
// cbmb_cfg
// register port: bar colour memory with per-entry valid bits, box registers
// ----------------------------------------------------------------------------
module cbmb_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cbmb_pkg::CBMB_ADDR_W-1:0]     paddr,
	input  logic [cbmb_pkg::CBMB_DATA_W-1:0]     pwdata,
	output logic [cbmb_pkg::CBMB_DATA_W-1:0]     prdata,
	output logic                                 pready,
	input  logic [1:0]                           rd_addr,
	output logic [cbmb_pkg::CBMB_PAIR_W-1:0]     rd_pair,
	output cbmb_pkg::cbmb_box_t                  box
);
	import cbmb_pkg::*;

	logic [CBMB_PAIR_W-1:0] mem [4];
	logic [3:0]             vld_q;
	logic [CBMB_PAIR_W-1:0] pix_rd_q;
	logic                   pix_vld_q;
	logic [CBMB_PAIR_W-1:0] apb_rd_q;
	logic                   apb_vld_q;
	logic [2:0]             apb_idx_q;
	logic                   box_en_q;
	logic [9:0]             box_bottom_q;
	logic [2:0]             idx;
	logic                   wr_en;
	logic                   wr_mem;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr_en  = psel & penable & pwrite & pready;
	assign wr_mem = wr_en && (idx inside {[REG_BARS_WY:REG_BARS_BK]});

	always_ff @(posedge clk) begin
		if (wr_mem) begin
			mem[idx[1:0]] <= pwdata[CBMB_PAIR_W-1:0];
		end
		pix_rd_q <= mem[rd_addr];
		apb_rd_q <= mem[idx[1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			pix_vld_q    <= 1'b0;
			apb_vld_q    <= 1'b0;
			apb_idx_q    <= '0;
			box_en_q     <= 1'b1;
			box_bottom_q <= BOX_BOTTOM_RST;
		end else begin
			pix_vld_q <= vld_q[rd_addr];
			if (psel && !penable) begin
				apb_idx_q <= idx;
				apb_vld_q <= vld_q[idx[1:0]];
			end
			if (wr_mem) begin
				vld_q[idx[1:0]] <= 1'b1;
			end
			if (wr_en && idx == REG_BOX_ENABLE) begin
				box_en_q <= pwdata[0];
			end
			if (wr_en && idx == REG_BOX_BOTTOM) begin
				box_bottom_q <= pwdata[9:0];
			end
		end
	end

	assign rd_pair    = pix_vld_q ? pix_rd_q : '0;
	assign box.en     = box_en_q;
	assign box.bottom = box_bottom_q;

	always_comb begin
		case (apb_idx_q)
			REG_BARS_WY, REG_BARS_CG, REG_BARS_MR, REG_BARS_BK: begin
				prdata = apb_vld_q ? 64'(apb_rd_q) : '0;
			end
			REG_BOX_ENABLE: prdata = 64'(box_en_q);
			REG_BOX_BOTTOM: prdata = 64'(box_bottom_q);
			default:        prdata = '0;
		endcase
	end

endmodule

/* rtl/cbmb_burst.sv */
// ----------------------------------------------------------------------------
// cbmb_burst
// multiburst luma: burst/offset split, phase product, remainder, period table
// ----------------------------------------------------------------------------
module cbmb_burst (
	input  logic       clk,
	input  logic [9:0] pixel_x,
	output logic [7:0] luma
);
	import cbmb_pkg::*;

	logic [9:0]  rel;
	logic [9:0]  n;
	logic [2:0]  k;
	logic [1:0]  mode;
	logic [7:0]  cval;

	logic [1:0]  mode_s1, mode_s2, mode_s3;
	logic [7:0]  cval_s1, cval_s2, cval_s3;
	logic [2:0]  k_s1;
	logic [6:0]  n_s1;
	logic [10:0] p;
	logic [10:0] p_s2, p_s3;
	logic [21:0] prod;
	logic [5:0]  q;
	logic [5:0]  q_s3;
	logic [10:0] r;

	// split the line into burst number and offset
	always_comb begin
		rel  = pixel_x - 10'(BURST_X0);
		k    = '0;
		for (int j = 1; j <= BURST_CNT; j++) begin
			if (rel >= 10'(j * BURST_STEP)) begin
				k = 3'(j);
			end
		end
		n    = rel - 10'(k) * 10'(BURST_STEP);
		mode = BL_CONST;
		cval = LUMA_MID;
		if (pixel_x < 10'd48) begin
			cval = LUMA_BLACK;
		end else if (pixel_x < 10'd96) begin
			cval = LUMA_WHITE;
		end else if (pixel_x < 10'(BURST_X0)) begin
			cval = LUMA_MID;
		end else if (k == 3'(BURST_CNT) || n >= 10'(BURST_LEN)) begin
			cval = LUMA_MID;
		end else if (k == 3'(BURST_CNT - 1)) begin
			mode = BL_P45;
		end else begin
			mode = BL_P27;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		cval_s1 <= cval;
		k_s1    <= k;
		n_s1    <= n[6:0];
	end

	assign p = (mode_s1 == BL_CONST) ? '0 : 11'(BURST_STEPS[k_s1]) * 11'(n_s1);

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		cval_s2 <= cval_s1;
		p_s2    <= p;
	end

	always_comb begin
		if (mode_s2 == BL_P45) begin
			prod = 22'(p_s2) * 22'(RECIP45);
			q    = prod[21:16];
		end else begin
			prod = 22'(p_s2) * 22'(RECIP27);
			q    = prod[20:15];
		end
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		cval_s3 <= cval_s2;
		p_s3    <= p_s2;
		q_s3    <= q;
	end

	always_comb begin
		r = '0;
		case (mode_s3)
			BL_P27: begin
				r    = p_s3 - 11'(q_s3) * 11'd27;
				luma = PER27[r[4:0]];
			end
			BL_P45: begin
				r    = p_s3 - 11'(q_s3) * 11'd45;
				luma = PER45[r[5:0]];
			end
			default: luma = cval_s3;
		endcase
	end

endmodule

/* rtl/colour_bar_multiburst_pixel_gen_unit.sv */
// ----------------------------------------------------------------------------
// colour_bar_multiburst_pixel_gen_unit
// 4:2:2 colour bar and multiburst test pattern, one sample per coordinate
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  pixel    | start, busy, pixel_x, pixel_y            | in
//  sample   | done, luma, chroma                       | out
//  regs     | psel, penable, pwrite, paddr, pwdata,    | in / out
//           | prdata, pready                           |
//
// one coordinate per clock; busy stays low
// a sample leaves on done after the s1, s2 and s3 stage registers and the output register,
// which carry the bar colour memory read and the three-stage burst phase path
// reset clears the pipeline valids and the colour memory valid bits
// done cannot be held off; the pipeline never stalls
// ----------------------------------------------------------------------------
module colour_bar_multiburst_pixel_gen_unit #(
	parameter int LINE_SAMPLES = cbmb_pkg::CBMB_LINE_SAMPLES,
	parameter int FRAME_ROWS   = cbmb_pkg::CBMB_FRAME_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [9:0]                       pixel_x,
	input  logic [9:0]                       pixel_y,
	output logic                             done,
	output logic [7:0]                       luma,
	output logic [7:0]                       chroma,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cbmb_pkg::CBMB_ADDR_W-1:0] paddr,
	input  logic [cbmb_pkg::CBMB_DATA_W-1:0] pwdata,
	output logic [cbmb_pkg::CBMB_DATA_W-1:0] prdata,
	output logic                             pready
);
	import cbmb_pkg::*;

	localparam int BAR_W   = ((LINE_SAMPLES / 8) > 0) ? (LINE_SAMPLES / 8) : 1;
	localparam int BAND_Y0 = FRAME_ROWS * 3 / 4;
	localparam int BAND_Y1 = FRAME_ROWS * 7 / 8;
	localparam int BOX_Y0  = FRAME_ROWS / 4;

	cbmb_box_t              box;
	logic [CBMB_PAIR_W-1:0] rd_pair;
	logic                   take;
	logic [2:0]             bar;
	logic                   in_band;
	logic                   in_box;
	logic [11:0]            x_ext;
	logic [11:0]            y_ext;
	logic [7:0]             burst_luma;

	logic                   vld_s1, vld_s2, vld_s3;
	logic                   band_s1, band_s2, band_s3;
	logic                   box_s1;
	logic                   odd_s1;
	logic                   hi_s1;
	logic [23:0]            colour;
	logic [7:0]             luma_c;
	logic [7:0]             chroma_c;
	logic [7:0]             luma_s2, luma_s3;
	logic [7:0]             chroma_s2, chroma_s3;
	logic                   done_q;
	logic [7:0]             luma_q;
	logic [7:0]             chroma_q;

	assign busy  = 1'b0;
	assign take  = start & ~busy;
	assign x_ext = 12'(pixel_x);
	assign y_ext = 12'(pixel_y);

	always_comb begin
		bar = '0;
		for (int i = 1; i < 8; i++) begin
			if (x_ext >= 12'(i * BAR_W)) begin
				bar = 3'(i);
			end
		end
	end

	assign in_band = (y_ext >= 12'(BAND_Y0)) && (y_ext < 12'(BAND_Y1));
	assign in_box  = box.en && (pixel_x >= 10'(BOX_X0)) && (pixel_x < 10'(BOX_X1)) &&
	                 (y_ext >= 12'(BOX_Y0)) && (pixel_y < box.bottom);

	cbmb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rd_addr (bar[2:1]),
		.rd_pair (rd_pair),
		.box     (box)
	);

	cbmb_burst u_burst (
		.clk     (clk),
		.pixel_x (pixel_x),
		.luma    (burst_luma)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		band_s1 <= in_band;
		box_s1  <= in_box;
		odd_s1  <= pixel_x[0];
		hi_s1   <= bar[0];
	end

	// colour word from memory, box and band override
	always_comb begin
		colour = hi_s1 ? rd_pair[47:24] : rd_pair[23:0];
		if (band_s1) begin
			luma_c   = LUMA_MID;
			chroma_c = CHROMA_MID;
		end else if (box_s1) begin
			luma_c   = LUMA_BLACK;
			chroma_c = CHROMA_MID;
		end else begin
			luma_c   = colour[7:0];
			chroma_c = odd_s1 ? colour[23:16] : colour[15:8];
		end
	end

	always_ff @(posedge clk) begin
		band_s2   <= band_s1;
		luma_s2   <= luma_c;
		chroma_s2 <= chroma_c;
		band_s3   <= band_s2;
		luma_s3   <= luma_s2;
		chroma_s3 <= chroma_s2;
		luma_q    <= band_s3 ? burst_luma : luma_s3;
		chroma_q  <= chroma_s3;
	end

	assign done   = done_q;
	assign luma   = luma_q;
	assign chroma = chroma_q;

endmodule

/* tb/tb_colour_bar_multiburst_pixel_gen_unit.sv */
// ----------------------------------------------------------------------------
// tb_colour_bar_multiburst_pixel_gen_unit
// self-checking bench for the colour bar / multiburst pattern generator:
// coordinates go in on the start/busy handshake with random gaps, each
// sample on done is matched against an in-bench pattern predictor, and the
// bar colours and box window are rewritten over the apb port between runs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_colour_bar_multiburst_pixel_gen_unit;

	import cbmb_pkg::*;

	localparam int BAR_WIDTH  = CBMB_LINE_SAMPLES / 8;
	localparam int BAND_TOP   = CBMB_FRAME_ROWS * 3 / 4;
	localparam int BAND_END   = CBMB_FRAME_ROWS * 7 / 8;
	localparam int BOX_TOP    = CBMB_FRAME_ROWS / 4;
	localparam int STALL_LIMIT = 1000;

	localparam logic [7:0] WAVE27 [27] = '{
		8'd126, 8'd141, 8'd156, 8'd168, 8'd179, 8'd187, 8'd191, 8'd192, 8'd189,
		8'd183, 8'd174, 8'd162, 8'd149, 8'd134, 8'd118, 8'd103, 8'd90,  8'd78,
		8'd69,  8'd63,  8'd60,  8'd61,  8'd65,  8'd73,  8'd84,  8'd96,  8'd111};

	localparam logic [7:0] WAVE45 [45] = '{
		8'd126, 8'd135, 8'd144, 8'd153, 8'd161, 8'd168, 8'd175, 8'd181, 8'd185,
		8'd189, 8'd191, 8'd192, 8'd192, 8'd190, 8'd187, 8'd183, 8'd178, 8'd172,
		8'd165, 8'd157, 8'd149, 8'd140, 8'd131, 8'd121, 8'd112, 8'd103, 8'd95,
		8'd87,  8'd80,  8'd74,  8'd69,  8'd65,  8'd62,  8'd60,  8'd60,  8'd61,
		8'd63,  8'd67,  8'd71,  8'd77,  8'd84,  8'd91,  8'd99,  8'd108, 8'd117};

	typedef struct packed {
		logic [9:0] x;
		logic [9:0] y;
		logic [7:0] luma;
		logic [7:0] chroma;
	} sample_t;

	class pattern_scoreboard;
		logic [47:0] bar_pairs [4];
		logic        box_en;
		logic [9:0]  box_bottom;
		sample_t     expected_samples [$];
		int          mismatches;

		function new();
			foreach (bar_pairs[i]) bar_pairs[i] = '0;
			box_en = 1'b1;
			box_bottom = BOX_BOTTOM_RST;
			mismatches = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] value);
			case (idx)
				REG_BARS_WY:    bar_pairs[0] = value[47:0];
				REG_BARS_CG:    bar_pairs[1] = value[47:0];
				REG_BARS_MR:    bar_pairs[2] = value[47:0];
				REG_BARS_BK:    bar_pairs[3] = value[47:0];
				REG_BOX_ENABLE: box_en = value[0];
				REG_BOX_BOTTOM: box_bottom = value[9:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] burst_level(int x);
			int rel, k, n;
			int steps [5];
			steps = '{1, 2, 4, 6, 8};
			if (x < 48) return LUMA_BLACK;
			if (x < 96) return LUMA_WHITE;
			if (x < BURST_X0) return LUMA_MID;
			rel = x - BURST_X0;
			k = rel / BURST_STEP;
			n = rel % BURST_STEP;
			if (k >= 6 || n >= BURST_LEN) return LUMA_MID;
			if (k < 5) return WAVE27[(steps[k] * n) % 27];
			return WAVE45[(16 * n) % 45];
		endfunction

		function void note_pixel(logic [9:0] x, logic [9:0] y);
			sample_t s;
			int bar;
			logic [23:0] colour;
			s.x = x;
			s.y = y;
			if (y >= BAND_TOP && y < BAND_END) begin
				s.luma = burst_level(x);
				s.chroma = CHROMA_MID;
			end else if (box_en && x >= BOX_X0 && x < BOX_X1 && y >= BOX_TOP &&
					y < box_bottom) begin
				s.luma = LUMA_BLACK;
				s.chroma = CHROMA_MID;
			end else begin
				bar = x / BAR_WIDTH;
				if (bar > 7) bar = 7;
				colour = bar[0] ? bar_pairs[bar >> 1][47:24] : bar_pairs[bar >> 1][23:0];
				s.luma = colour[7:0];
				s.chroma = x[0] ? colour[23:16] : colour[15:8];
			end
			expected_samples.push_back(s);
		endfunction

		function void check_sample(logic [7:0] luma, logic [7:0] chroma);
			sample_t s;
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: luma %0d chroma %0d", luma, chroma);
				return;
			end
			s = expected_samples.pop_front();
			if (luma !== s.luma || chroma !== s.chroma) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch x=%0d y=%0d: expected luma %0d chroma %0d, got luma %0d chroma %0d",
						s.x, s.y, s.luma, s.chroma, luma, chroma);
			end
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [9:0]             pixel_x;
	logic [9:0]             pixel_y;
	logic                   done;
	logic [7:0]             luma;
	logic [7:0]             chroma;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [CBMB_ADDR_W-1:0] paddr;
	logic [CBMB_DATA_W-1:0] pwdata;
	logic [CBMB_DATA_W-1:0] prdata;
	logic                   pready;

	pattern_scoreboard sb = new();
	int stall_cycles = 0;

	colour_bar_multiburst_pixel_gen_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .done(done), .luma(luma), .chroma(chroma),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_sample(luma, chroma);
	end

	// ends the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog expired with %0d words outstanding", sb.pending());
				$display("colour_bar_multiburst_pixel_gen_unit verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// called at a falling edge; leaves at the falling edge after acceptance
	task automatic send_pixel(input logic [9:0] x, input logic [9:0] y, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (busy);
		sb.note_pixel(x, y);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		start <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [63:0] random_pair();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		v[63:48] = '0;
		return v;
	endfunction

	task automatic write_bars(input int mode);
		logic [63:0] v;
		for (int i = 0; i < 4; i++) begin
			case (mode)
				0: v = 64'd0;
				1: v = 64'h0000_FFFF_FFFF_FFFF;
				default: v = random_pair();
			endcase
			write_reg(REG_BARS_WY + 3'(i), v);
		end
	endtask

	function automatic void random_coord(output logic [9:0] x, output logic [9:0] y);
		int kind;
		int top;
		kind = $urandom_range(0, 9);
		x = (kind == 9 || $urandom_range(0, 15) == 0) ? 10'($urandom_range(0, 1023)) :
			10'($urandom_range(0, CBMB_LINE_SAMPLES - 1));
		if (kind <= 3) begin
			y = 10'($urandom_range(BAND_TOP, BAND_END - 1));
		end else if (kind <= 5) begin
			top = (sb.box_bottom > BOX_TOP) ? sb.box_bottom + 2 : BOX_TOP + 4;
			x = 10'($urandom_range(BOX_X0 - 6, BOX_X1 + 6));
			y = 10'($urandom_range(BOX_TOP - 3, top));
		end else if (kind <= 8) begin
			y = 10'($urandom_range(0, CBMB_FRAME_ROWS - 1));
		end else begin
			y = 10'($urandom_range(0, 1023));
		end
	endfunction

	initial begin
		logic [9:0] dx [$];
		logic [9:0] dy [$];
		logic [9:0] x, y;
		logic [9:0] bottom;
		bit steady;
		int gap;

		arst_n = 1'b0;
		start = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset colours and box
		send_pixel(10'd0, 10'd0, 0);
		send_pixel(10'd300, 10'd150, 0);
		send_pixel(10'd719, 10'd575, 1);
		send_pixel(10'd200, 10'd440, 0);
		stop_sending();
		drain();

		write_bars(2);
		dx = '{0, 1, 89, 90, 179, 180, 539, 540, 300, 719, 720, 1023,
			0, 47, 48, 95, 96, 111, 112, 207, 208, 611, 711, 712, 1023};
		dy = '{0, 1, 10, 11, 143, 144, 217, 144, 218, 300, 301, 1023,
			432, 433, 440, 503, 504, 450, 431, 460, 460, 470, 470, 470, 470};
		foreach (dx[i]) send_pixel(dx[i], dy[i], (i % 5 == 3) ? 2 : 0);
		stop_sending();
		drain();

		for (int phase = 0; phase < 7; phase++) begin
			write_bars(phase < 2 ? phase : 2);
			case (phase)
				0: begin write_reg(REG_BOX_ENABLE, 64'd1); bottom = 10'd575; end
				1: begin write_reg(REG_BOX_ENABLE, 64'd1); bottom = 10'd0; end
				2: begin write_reg(REG_BOX_ENABLE, 64'd0); bottom = 10'd575; end
				3: begin write_reg(REG_BOX_ENABLE, 64'd1); bottom = 10'd144; end
				4: bottom = 10'd145;
				5: bottom = 10'($urandom_range(146, 575));
				default: bottom = BOX_BOTTOM_RST;
			endcase
			write_reg(REG_BOX_BOTTOM, 64'(bottom));
			// band rows overlapping the box
			if (phase == 0) begin
				send_pixel(10'd300, 10'd432, 0);
				send_pixel(10'd539, 10'd503, 0);
				send_pixel(10'd180, 10'd504, 0);
			end
			steady = (phase == 1) || ($urandom_range(0, 2) == 0);
			for (int i = 0; i < 75; i++) begin
				random_coord(x, y);
				gap = (steady || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
				send_pixel(x, y, gap);
			end
			stop_sending();
			drain();
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("colour_bar_multiburst_pixel_gen_unit verification clean");
		else
			$display("colour_bar_multiburst_pixel_gen_unit verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/cbmb_pkg.sv
rtl/cbmb_cfg.sv
rtl/cbmb_burst.sv
rtl/colour_bar_multiburst_pixel_gen_unit.sv
tb/tb_colour_bar_multiburst_pixel_gen_unit.sv
